// ----- sv/pcmvm_pkg.sv -----
// ----------------------------------------------------------------------------
// pcmvm_pkg: shared definitions of the PCM sample voice mixer
// Constants, command codes and the structs passed between the mixer modules.
// ----------------------------------------------------------------------------
package pcmvm_pkg;

	localparam int VOICES      = 8;
	localparam int MEM_AW      = 16;
	localparam int OUTPUT_RATE = 11025;

	localparam int VID_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int POS_W  = 32;
	localparam int STEP_W = 20;
	localparam int LEN_W  = 16;
	localparam int VOL_W  = 7;
	localparam int SUM_W  = 18 + $clog2(VOICES);

	// Floor of 2^32 / OUTPUT_RATE, used to estimate the playback step.
	localparam int STEP_RECIP = 389566;

	typedef enum logic [2:0] {
		CMD_LOAD   = 3'd0,
		CMD_START  = 3'd1,
		CMD_SETVOL = 3'd2,
		CMD_STOP   = 3'd3,
		CMD_TICK   = 3'd4
	} cmd_t;

	typedef struct packed {
		logic              start;
		logic              setvol;
		logic              stop;
		logic [2:0]        voice;
		logic [15:0]       base;
		logic [LEN_W-1:0]  len;
		logic [STEP_W-1:0] step;
		logic [VOL_W-1:0]  vol;
	} cell_ctl_t;

	typedef struct packed {
		logic              valid;
		logic [MEM_AW-1:0] addr;
		logic [VOL_W-1:0]  vol;
	} mix_req_t;

endpackage

// ----- sv/pcmvm_if.sv -----
// ----------------------------------------------------------------------------
// pcmvm_cmd_if and pcmvm_res_if: item channels of the voice mixer
// Valid and ready handshake with the command and result payloads.
// ----------------------------------------------------------------------------
interface pcmvm_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [2:0]  voice;
	logic [15:0] mem_address;
	logic [7:0]  sample_byte;
	logic [15:0] sound_length;
	logic [15:0] sound_rate;
	logic [6:0]  volume;

	modport source (output valid, cmd, voice, mem_address, sample_byte, sound_length,
		sound_rate, volume, input ready);
	modport sink (input valid, cmd, voice, mem_address, sample_byte, sound_length,
		sound_rate, volume, output ready);
endinterface

interface pcmvm_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mixed_sample;
	logic [7:0]         active_mask;

	modport source (output valid, mixed_sample, active_mask, input ready);
	modport sink (input valid, mixed_sample, active_mask, output ready);
endinterface

// ----- sv/pcmvm_step_div.sv -----
// ----------------------------------------------------------------------------
// pcmvm_step_div: playback step divider
// Computes (rate << 16) / OUTPUT_RATE in three stages by reciprocal estimate.
// ----------------------------------------------------------------------------
module pcmvm_step_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [15:0]                rate,
	output logic                       done,
	output logic [pcmvm_pkg::STEP_W-1:0] step
);

	logic [15:0]                  rate_q;
	logic [2:0]                   ph_q;
	logic                         done_q;
	logic [34:0]                  prod;
	logic [pcmvm_pkg::STEP_W-1:0] est_q;
	logic [31:0]                  back_q;
	logic [31:0]                  rem;
	logic [pcmvm_pkg::STEP_W-1:0] step_q;

	// The estimate is the exact quotient or one below it.
	assign prod = 35'(rate_q) * 35'(pcmvm_pkg::STEP_RECIP);
	assign rem  = {rate_q, 16'd0} - back_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= '0;
			done_q <= 1'b0;
		end else begin
			ph_q   <= {ph_q[1:0], go};
			done_q <= ph_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rate_q <= rate;
		end
		est_q  <= pcmvm_pkg::STEP_W'(prod[34:16]);
		back_q <= 32'(34'(est_q) * 34'(pcmvm_pkg::OUTPUT_RATE));
		step_q <= (rem >= 32'(pcmvm_pkg::OUTPUT_RATE)) ? est_q + pcmvm_pkg::STEP_W'(1)
			: est_q;
	end

	assign done = done_q;
	assign step = step_q;

endmodule

// ----- sv/pcmvm_cell.sv -----
// ----------------------------------------------------------------------------
// pcmvm_cell: one voice of the mixer chain
// Holds a voice's state, and issues its sample fetch when the token passes.
// ----------------------------------------------------------------------------
module pcmvm_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [pcmvm_pkg::VID_W-1:0]  id,
	input  pcmvm_pkg::cell_ctl_t         ctl,
	input  logic                         tok_in,
	output logic                         tok_out,
	input  pcmvm_pkg::mix_req_t          req_in,
	output pcmvm_pkg::mix_req_t          req_out,
	output logic                         active
);

	logic [15:0]                   base_q;
	logic [pcmvm_pkg::LEN_W-1:0]   len_q;
	logic [pcmvm_pkg::POS_W-1:0]   pos_q;
	logic [pcmvm_pkg::STEP_W-1:0]  step_q;
	logic [pcmvm_pkg::VOL_W-1:0]   vol_q;
	logic                          active_q;
	logic                          tok_q;
	logic                          hit;
	logic                          ended;
	logic                          fetch;
	logic [16:0]                   addr_sum;

	assign hit      = 32'(ctl.voice) == 32'(id);
	assign ended    = pos_q[31:16] >= len_q;
	assign fetch    = tok_q && active_q && !ended;
	assign addr_sum = {1'b0, base_q} + {1'b0, pos_q[31:16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			tok_q    <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (tok_q && active_q && ended) begin
				active_q <= 1'b0;
			end
			if (ctl.start && hit) begin
				active_q <= 1'b1;
			end else if (ctl.stop && hit) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fetch) begin
			pos_q <= pos_q + pcmvm_pkg::POS_W'(step_q);
		end
		if (ctl.start && hit) begin
			base_q <= ctl.base;
			len_q  <= ctl.len;
			pos_q  <= '0;
			step_q <= ctl.step;
			vol_q  <= ctl.vol;
		end else if (ctl.setvol && hit) begin
			vol_q <= ctl.vol;
		end
	end

	always_comb begin
		req_out = req_in;
		if (fetch) begin
			req_out.valid = 1'b1;
			req_out.addr  = pcmvm_pkg::MEM_AW'(addr_sum);
			req_out.vol   = vol_q;
		end
	end

	assign tok_out = tok_q;
	assign active  = active_q;

endmodule

// ----- sv/pcm_sample_voice_mixer.sv -----
// ----------------------------------------------------------------------------
// pcm_sample_voice_mixer: eight-voice 8-bit PCM playback mixer
// Sample memory, a chain of voice cells, a step divider and the mix pipeline.
// ----------------------------------------------------------------------------
// Load, set volume and stop items leave the mixer idle. A start item holds it
// in the divide state while the three-stage reciprocal pipeline computes the
// step. During a tick item a token walks the voice chain one cell
// per cycle, sharing the single sample memory read port, and the last fetch
// then passes the read, multiply and sum stages before the result item is
// registered. A tick whose result finds the previous one still waiting holds
// until that one leaves. Commands are taken again once a tick's result is
// registered, even while that result waits.
module pcm_sample_voice_mixer (
	input  logic               clk,
	input  logic               arst_n,
	pcmvm_cmd_if.sink          command,
	pcmvm_res_if.source        result
);

	localparam int V     = pcmvm_pkg::VOICES;
	localparam int CNT_W = $clog2(V + 2);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_TICK, S_FIN} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          acc;
	logic                          div_go;
	logic                          div_done;
	logic [pcmvm_pkg::STEP_W-1:0]  div_step;
	logic [15:0]                   rate_sel;
	logic [2:0]                    voice_q;
	logic [15:0]                   base_q;
	logic [15:0]                   len_q;
	logic [6:0]                    vol_q;
	pcmvm_pkg::cell_ctl_t          ctl;
	logic [V:0]                    tok;
	pcmvm_pkg::mix_req_t           req [V+1];
	logic [V-1:0]                  act;
	logic [7:0]                    mem_q [2**pcmvm_pkg::MEM_AW];
	logic [7:0]                    rd_s1;
	logic [6:0]                    vol_s1;
	logic                          v_s1;
	logic [13:0]                   p_s2;
	logic                          neg_s2;
	logic                          v_s2;
	logic [7:0]                    mag;
	logic [14:0]                   dbl;
	logic [30:0]                   recip;
	logic [15:0]                   contrib;
	logic signed [pcmvm_pkg::SUM_W-1:0] sum_q;
	logic signed [pcmvm_pkg::SUM_W-1:0] sum_add;
	logic signed [15:0]            sat;
	logic [7:0]                    mask;
	logic                          out_valid_q;
	logic signed [15:0]            ms_q;
	logic [7:0]                    mask_q;

	assign command.ready = state_q == S_IDLE;
	assign acc           = command.valid && command.ready;
	assign div_go        = acc && command.cmd == pcmvm_pkg::CMD_START;
	assign rate_sel      = (command.sound_rate == 16'd0) ? 16'(pcmvm_pkg::OUTPUT_RATE)
		: command.sound_rate;

	pcmvm_step_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.rate   (rate_sel),
		.done   (div_done),
		.step   (div_step)
	);

	always_comb begin
		ctl.start  = state_q == S_DIV && div_done;
		ctl.setvol = acc && command.cmd == pcmvm_pkg::CMD_SETVOL;
		ctl.stop   = acc && command.cmd == pcmvm_pkg::CMD_STOP;
		ctl.voice  = (state_q == S_DIV) ? voice_q : command.voice;
		ctl.base   = base_q;
		ctl.len    = len_q;
		ctl.step   = div_step;
		ctl.vol    = (state_q == S_DIV) ? vol_q : command.volume;
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			voice_q <= command.voice;
			base_q  <= command.mem_address;
			len_q   <= command.sound_length;
			vol_q   <= command.volume;
		end
	end

	assign tok[0] = acc && command.cmd == pcmvm_pkg::CMD_TICK;
	assign req[0] = '0;

	for (genvar i = 0; i < V; i++) begin : g_cell
		pcmvm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.id      (pcmvm_pkg::VID_W'(i)),
			.ctl     (ctl),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.req_in  (req[i]),
			.req_out (req[i+1]),
			.active  (act[i])
		);
	end

	always_ff @(posedge clk) begin
		if (acc && command.cmd == pcmvm_pkg::CMD_LOAD) begin
			mem_q[command.mem_address[pcmvm_pkg::MEM_AW-1:0]] <= command.sample_byte;
		end
		rd_s1 <= mem_q[req[V].addr];
	end

	assign mag     = rd_s1[7] ? (rd_s1 - 8'd128) : (8'd128 - rd_s1);
	assign dbl     = {p_s2, 1'b0};
	// Division by 127 of the doubled product, exact for values below 32768.
	assign recip   = 31'({1'b0, dbl} + 16'd1) * 31'd16513;
	assign contrib = 16'(dbl) + 16'(recip[30:21]);
	assign sum_add = neg_s2 ? -pcmvm_pkg::SUM_W'($signed({1'b0, contrib}))
		: pcmvm_pkg::SUM_W'($signed({1'b0, contrib}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req[V].valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		vol_s1 <= req[V].vol;
		p_s2   <= 14'(mag * vol_s1);
		neg_s2 <= !rd_s1[7] && rd_s1 != 8'd128;
		if (tok[0]) begin
			sum_q <= '0;
		end else if (v_s2) begin
			sum_q <= sum_q + sum_add;
		end
	end

	always_comb begin
		if (sum_q > pcmvm_pkg::SUM_W'(32767)) begin
			sat = 16'sd32767;
		end else if (sum_q < -pcmvm_pkg::SUM_W'(32768)) begin
			sat = -16'sd32768;
		end else begin
			sat = 16'(sum_q);
		end
		mask = '0;
		for (int i = 0; i < V && i < 8; i++) begin
			mask[i] = act[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (div_go) begin
						state_q <= S_DIV;
					end else if (tok[0]) begin
						state_q <= S_TICK;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(V + 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || result.ready)) begin
			ms_q   <= sat;
			mask_q <= mask;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.mixed_sample = ms_q;
	assign result.active_mask  = mask_q;

`ifndef NO_ASSERTIONS
	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok[V:1]))
		else $error("More than one voice cell holds the token.");
	a_tok_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tok[V:1] != '0 |-> state_q == S_TICK)
		else $error("Token in the chain outside a tick.");
	a_fetch_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		req[V].valid |-> state_q == S_TICK && cnt_q < CNT_W'(V))
		else $error("Sample fetch outside the token walk.");
`endif

endmodule
